// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the cursor overlay RTL.
// No dependencies; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition a must be accompanied by condition b in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("cursor overlay check failed");

// Condition a must be followed by condition b in the next cycle.
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("cursor overlay check failed");

// Condition a must never hold.
`define ASSERT_NEVER(label, clk, rst, a) \
  label: assert property (@(posedge clk) disable iff (rst) !(a)) \
    else $error("cursor overlay check failed");

`endif

// ----- rtl/caxo_pkg.sv -----
// Shared types, codes and lookup functions for the cursor overlay.
// No dependencies; imported by every module of the block except caxo_fifo.
package caxo_pkg;

  // Fixed field widths
  localparam int PIXEL_BITS = 8;
  localparam int POS_W      = 12;
  localparam int ROW_W      = 4;
  localparam int PLANE_W    = 16;
  localparam int OP_W       = 3;
  localparam int HOT_W      = 5;
  localparam int HIDE_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int DIFF_W     = 14;

  // Parameter defaults
  localparam int CURSOR_W_DEF   = 16;
  localparam int CURSOR_H_DEF   = 16;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [HIDE_W-1:0] HIDE_MAX = 4'd15;

  // Input op codes
  localparam logic [OP_W-1:0] OPC_PIXEL  = 3'd0;
  localparam logic [OP_W-1:0] OPC_LOAD   = 3'd1;
  localparam logic [OP_W-1:0] OPC_MOVE   = 3'd2;
  localparam logic [OP_W-1:0] OPC_HIDE   = 3'd3;
  localparam logic [OP_W-1:0] OPC_UNHIDE = 3'd4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOT_X  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOT_Y  = 2'd2;

  // Shades
  localparam logic [PIXEL_BITS-1:0] SHADE_BLACK = 8'hFF;
  localparam logic [PIXEL_BITS-1:0] SHADE_WHITE = 8'h00;

  typedef enum logic [2:0] {
    K_PIXEL,
    K_LOAD,
    K_MOVE,
    K_HIDE,
    K_UNHIDE,
    K_NOP
  } kind_t;

  // Classified command passed from front to back
  typedef struct packed {
    kind_t                  kind;
    logic [POS_W-1:0]       x;
    logic [POS_W-1:0]       y;
    logic [PIXEL_BITS-1:0]  pixel;
    logic [ROW_W-1:0]       row;
    logic [PLANE_W-1:0]     clr;
    logic [PLANE_W-1:0]     set;
  } cmd_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0]  pixel;
    logic                   shown;
  } res_t;

  localparam int CMD_W = $bits(cmd_t);
  localparam int RES_W = $bits(res_t);

  // AND mask for a {clear, set} bit pair
  function automatic logic [PIXEL_BITS-1:0] mask_of(input logic [1:0] sel);
    logic [PIXEL_BITS-1:0] m;
    unique case (sel)
      2'b00:   m = 8'hFF;
      2'b01:   m = 8'h00;
      2'b10:   m = 8'h00;
      default: m = 8'hFF;
    endcase
    return m;
  endfunction

  // XOR data for a {clear, set} bit pair
  function automatic logic [PIXEL_BITS-1:0] data_of(input logic [1:0] sel);
    logic [PIXEL_BITS-1:0] d;
    unique case (sel)
      2'b00:   d = 8'h00;
      2'b01:   d = SHADE_BLACK;
      2'b10:   d = SHADE_WHITE;
      default: d = 8'hFF;
    endcase
    return d;
  endfunction

endpackage

// ----- rtl/caxo_fifo.sv -----
// Small register-based queue used between front, back and result side.
// Depends on assert_macros.svh.
module caxo_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);
  `include "assert_macros.svh"

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign dout    = mem[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store payload
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  `ASSERT_NEVER(a_count_range, clk, rst, count > CW'(DEPTH))
  `ASSERT_NEXT(a_push_fills, clk, rst, do_push, !empty)
  `ASSERT_NEXT(a_last_drains, clk, rst, do_pop && !do_push && count == CW'(1), empty)

endmodule

// ----- rtl/caxo_front.sv -----
// Front end: takes input items and classifies them into commands.
// Depends on caxo_pkg.
module caxo_front #(
  parameter int CURSOR_H = caxo_pkg::CURSOR_H_DEF
) (
  input  logic                                 push,
  input  logic                                 queue_full,
  input  logic [caxo_pkg::OP_W-1:0]            op,
  input  logic [caxo_pkg::POS_W-1:0]           pos_x,
  input  logic [caxo_pkg::POS_W-1:0]           pos_y,
  input  logic [caxo_pkg::PIXEL_BITS-1:0]      pixel_in,
  input  logic [caxo_pkg::ROW_W-1:0]           row_index,
  input  logic [caxo_pkg::PLANE_W-1:0]         clear_bits,
  input  logic [caxo_pkg::PLANE_W-1:0]         set_bits,
  output logic                                 cmd_push,
  output caxo_pkg::cmd_t                       cmd
);
  import caxo_pkg::*;

  logic row_ok;

  assign cmd_push = push & ~queue_full;

  // Drop loads aimed past the cursor height
  assign row_ok = (32'(row_index) < 32'(CURSOR_H));

  // Classify the op
  always_comb begin
    cmd.x     = pos_x;
    cmd.y     = pos_y;
    cmd.pixel = pixel_in;
    cmd.row   = row_index;
    cmd.clr   = clear_bits;
    cmd.set   = set_bits;
    unique case (op)
      OPC_PIXEL:  cmd.kind = K_PIXEL;
      OPC_LOAD:   cmd.kind = row_ok ? K_LOAD : K_NOP;
      OPC_MOVE:   cmd.kind = K_MOVE;
      OPC_HIDE:   cmd.kind = K_HIDE;
      OPC_UNHIDE: cmd.kind = K_UNHIDE;
      default:    cmd.kind = K_NOP;
    endcase
  end

endmodule

// ----- rtl/caxo_back.sv -----
// Back end: holds cursor state and registers, executes commands in order.
// Depends on caxo_pkg and assert_macros.svh.
module caxo_back #(
  parameter int CURSOR_W = caxo_pkg::CURSOR_W_DEF,
  parameter int CURSOR_H = caxo_pkg::CURSOR_H_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [caxo_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [caxo_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 cmd_valid,
  input  caxo_pkg::cmd_t                       cmd,
  output logic                                 cmd_pop,
  input  logic                                 res_full,
  output logic                                 res_push,
  output caxo_pkg::res_t                       res
);
  import caxo_pkg::*;
  `include "assert_macros.svh"

  // Only the first sixteen rows and columns can ever be non-transparent
  localparam int ROWS  = (CURSOR_H < PLANE_W) ? CURSOR_H : PLANE_W;
  localparam int COLS  = (CURSOR_W < PLANE_W) ? CURSOR_W : PLANE_W;
  localparam int RIDX  = $clog2(ROWS);
  localparam logic signed [DIFF_W-1:0] COL_LIM = DIFF_W'(COLS);
  localparam logic signed [DIFF_W-1:0] ROW_LIM = DIFF_W'(ROWS);

  logic                     cfg_enable;
  logic signed [HOT_W-1:0]  hot_x;
  logic signed [HOT_W-1:0]  hot_y;
  logic [POS_W-1:0]         pointer_x;
  logic [POS_W-1:0]         pointer_y;
  logic [HIDE_W-1:0]        hide_count;
  logic [HIDE_W-1:0]        hide_count_next;
  logic [PLANE_W-1:0]       clear_plane [ROWS];
  logic [PLANE_W-1:0]       set_plane [ROWS];

  logic                     go;
  logic                     hide_go;
  logic                     pixel_go;
  logic                     shown_now;
  logic signed [DIFF_W-1:0] origin_x;
  logic signed [DIFF_W-1:0] origin_y;
  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;
  logic                     in_rect;
  logic [3:0]               bit_idx;
  logic [RIDX-1:0]          row_sel;
  logic [1:0]               sel;
  logic [PIXEL_BITS-1:0]    blended;

  assign go       = cmd_valid & ~res_full;
  assign cmd_pop  = go;
  assign res_push = go;
  assign hide_go  = go && (cmd.kind == K_HIDE);
  assign pixel_go = go && (cmd.kind == K_PIXEL);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_enable <= 1'b0;
      hot_x      <= '0;
      hot_y      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENABLE: cfg_enable <= cfg_data[0];
        REG_HOT_X:  hot_x <= cfg_data[HOT_W-1:0];
        REG_HOT_Y:  hot_y <= cfg_data[HOT_W-1:0];
        default:    ;
      endcase
    end
  end

  // Locate the pixel relative to the cursor rectangle
  always_comb begin
    origin_x = $signed({2'b00, pointer_x}) - DIFF_W'(hot_x);
    origin_y = $signed({2'b00, pointer_y}) - DIFF_W'(hot_y);
    dx       = $signed({2'b00, cmd.x}) - origin_x;
    dy       = $signed({2'b00, cmd.y}) - origin_y;
    in_rect  = !dx[DIFF_W-1] && (dx < COL_LIM) && !dy[DIFF_W-1] && (dy < ROW_LIM);
    bit_idx  = 4'hF - dx[3:0];
    row_sel  = dy[RIDX-1:0];
  end

  // Apply AND mask and XOR data
  assign shown_now = cfg_enable && (hide_count == '0);
  assign sel       = {clear_plane[row_sel][bit_idx], set_plane[row_sel][bit_idx]};
  assign blended   = (cmd.pixel & mask_of(sel)) ^ data_of(sel);

  // Step the hide counter
  always_comb begin
    hide_count_next = hide_count;
    if (go && cmd.kind == K_HIDE && hide_count != HIDE_MAX) begin
      hide_count_next = hide_count + 1'b1;
    end else if (go && cmd.kind == K_UNHIDE && hide_count != '0) begin
      hide_count_next = hide_count - 1'b1;
    end
  end

  // Form the result
  always_comb begin
    res.pixel = '0;
    if (cmd.kind == K_PIXEL) begin
      res.pixel = (shown_now && in_rect) ? blended : cmd.pixel;
    end
    res.shown = cfg_enable && (hide_count_next == '0);
  end

  // Update pointer and hide state
  always_ff @(posedge clk) begin
    if (rst) begin
      pointer_x  <= '0;
      pointer_y  <= '0;
      hide_count <= '0;
    end else begin
      hide_count <= hide_count_next;
      if (go && cmd.kind == K_MOVE) begin
        pointer_x <= cmd.x;
        pointer_y <= cmd.y;
      end
    end
  end

  // Load cursor rows
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ROWS; i++) begin
        clear_plane[i] <= '0;
        set_plane[i]   <= '0;
      end
    end else if (go && cmd.kind == K_LOAD) begin
      clear_plane[cmd.row[RIDX-1:0]] <= cmd.clr;
      set_plane[cmd.row[RIDX-1:0]]   <= cmd.set;
    end
  end

  `ASSERT_NEXT(a_hide_sat, clk, rst, hide_go && hide_count == HIDE_MAX, hide_count == HIDE_MAX)
  `ASSERT_IMPLIES(a_shown_needs_en, clk, rst, res_push && res.shown, cfg_enable)
  `ASSERT_IMPLIES(a_hidden_passes, clk, rst, pixel_go && !shown_now, res.pixel == cmd.pixel)

endmodule

// ----- rtl/cursor_and_xor_overlay_unit.sv -----
// AND-XOR cursor overlay on an 8-bit pixel stream: items enter through a queue-style
// push/full port, are classified by a front end, wait in a two-entry command queue, and are
// executed in order by a back end that keeps the 16x16 two-plane cursor image, the pointer and
// the hide counter; every item gives exactly one result, read through an empty/pop port from a
// two-entry result queue. One item is taken and one result produced per clock while the result
// queue has room, through the command queue and then the result queue. Configuration (enable,
// hotspot x and y) must be written by the user via cfg_we/cfg_index/cfg_data only while the
// block is idle (not enforced). Depends on caxo_pkg, caxo_fifo, caxo_front and caxo_back.
module cursor_and_xor_overlay_unit #(
  parameter int CURSOR_W = caxo_pkg::CURSOR_W_DEF,
  parameter int CURSOR_H = caxo_pkg::CURSOR_H_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  output logic                                 full,
  input  logic [caxo_pkg::OP_W-1:0]            op,
  input  logic [caxo_pkg::POS_W-1:0]           pos_x,
  input  logic [caxo_pkg::POS_W-1:0]           pos_y,
  input  logic [caxo_pkg::PIXEL_BITS-1:0]      pixel_in,
  input  logic [caxo_pkg::ROW_W-1:0]           row_index,
  input  logic [caxo_pkg::PLANE_W-1:0]         clear_bits,
  input  logic [caxo_pkg::PLANE_W-1:0]         set_bits,
  output logic                                 empty,
  input  logic                                 pop,
  output logic [caxo_pkg::PIXEL_BITS-1:0]      pixel_out,
  output logic                                 cursor_shown,
  input  logic                                 cfg_we,
  input  logic [caxo_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [caxo_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import caxo_pkg::*;

  logic             cmd_push;
  cmd_t             cmd_in;
  logic [CMD_W-1:0] cmd_bits;
  logic             cmd_empty;
  logic             cmd_pop;
  logic             res_full;
  logic             res_push;
  res_t             res_in;
  logic [RES_W-1:0] res_bits;
  res_t             res_out;

  // Classify incoming items
  caxo_front #(
    .CURSOR_H (CURSOR_H)
  ) u_front (
    .push       (push),
    .queue_full (full),
    .op         (op),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pixel_in   (pixel_in),
    .row_index  (row_index),
    .clear_bits (clear_bits),
    .set_bits   (set_bits),
    .cmd_push   (cmd_push),
    .cmd        (cmd_in)
  );

  // Hold commands between front and back
  caxo_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (full),
    .pop   (cmd_pop),
    .dout  (cmd_bits),
    .empty (cmd_empty)
  );

  // Execute commands
  caxo_back #(
    .CURSOR_W (CURSOR_W),
    .CURSOR_H (CURSOR_H)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (~cmd_empty),
    .cmd       (cmd_t'(cmd_bits)),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  // Hold results until transferred
  caxo_fifo #(
    .WIDTH (RES_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_bits),
    .empty (empty)
  );

  assign res_out      = res_t'(res_bits);
  assign pixel_out    = res_out.pixel;
  assign cursor_shown = res_out.shown;

endmodule

// ----- tb/overlay_checker.sv -----
// Scoreboard for the cursor overlay: tracks cursor state from the observed transfers,
// predicts one result per accepted item and compares each popped result in order.
// Depends on caxo_pkg for widths, op codes and register indexes.
`timescale 1ns / 100ps

module overlay_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  input  logic                                 full,
  input  logic [caxo_pkg::OP_W-1:0]            op,
  input  logic [caxo_pkg::POS_W-1:0]           pos_x,
  input  logic [caxo_pkg::POS_W-1:0]           pos_y,
  input  logic [caxo_pkg::PIXEL_BITS-1:0]      pixel_in,
  input  logic [caxo_pkg::ROW_W-1:0]           row_index,
  input  logic [caxo_pkg::PLANE_W-1:0]         clear_bits,
  input  logic [caxo_pkg::PLANE_W-1:0]         set_bits,
  input  logic                                 empty,
  input  logic                                 pop,
  input  logic [caxo_pkg::PIXEL_BITS-1:0]      pixel_out,
  input  logic                                 cursor_shown,
  input  logic                                 cfg_we,
  input  logic [caxo_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [caxo_pkg::CFG_DATA_W-1:0]      cfg_data,
  output int                                   fail_count,
  output int                                   pending
);
  import caxo_pkg::*;

  localparam int CURSOR_COLS = CURSOR_W_DEF;
  localparam int CURSOR_ROWS = CURSOR_H_DEF;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] pixel;
    logic                  shown;
  } overlay_result_t;

  // Mirror of the cursor image, pointer, hide level and registers
  logic [PLANE_W-1:0]     clear_rows [CURSOR_ROWS];
  logic [PLANE_W-1:0]     set_rows [CURSOR_ROWS];
  logic [POS_W-1:0]       ptr_x;
  logic [POS_W-1:0]       ptr_y;
  logic [HIDE_W-1:0]      hide_level;
  logic                   show_enable;
  logic signed [HOT_W-1:0] hot_dx;
  logic signed [HOT_W-1:0] hot_dy;

  overlay_result_t awaited_results [$];
  int              errors = 0;

  function automatic logic cursor_visible();
    return show_enable && (hide_level == '0);
  endfunction

  // AND-XOR blend of one framebuffer pixel under the cursor rectangle
  function automatic logic [PIXEL_BITS-1:0] blended_pixel(input logic [PIXEL_BITS-1:0] px,
                                                          input logic [POS_W-1:0] x,
                                                          input logic [POS_W-1:0] y);
    int   col_off;
    int   row_off;
    logic c;
    logic s;
    col_off = int'(x) - (int'(ptr_x) - int'(hot_dx));
    row_off = int'(y) - (int'(ptr_y) - int'(hot_dy));
    if (!cursor_visible() || col_off < 0 || col_off >= CURSOR_COLS ||
        row_off < 0 || row_off >= CURSOR_ROWS || col_off >= PLANE_W) begin
      return px;
    end
    c = clear_rows[row_off][PLANE_W-1-col_off];
    s = set_rows[row_off][PLANE_W-1-col_off];
    case ({c, s})
      2'b00:   return px;
      2'b01:   return SHADE_BLACK;
      2'b10:   return SHADE_WHITE;
      default: return ~px;
    endcase
  endfunction

  task automatic flag(input string what, input overlay_result_t want,
                      input overlay_result_t seen);
    errors++;
    if (errors <= REPORT_MAX) begin
      $display("%0t: %s: expected pixel %02h shown %0b, got pixel %02h shown %0b",
               $realtime, what, want.pixel, want.shown, seen.pixel, seen.shown);
    end
  endtask

  always @(posedge clk) begin
    overlay_result_t seen;
    overlay_result_t want;
    if (rst) begin
      for (int r = 0; r < CURSOR_ROWS; r++) begin
        clear_rows[r] = '0;
        set_rows[r] = '0;
      end
      ptr_x = '0;
      ptr_y = '0;
      hide_level = '0;
      show_enable = 1'b0;
      hot_dx = '0;
      hot_dy = '0;
      awaited_results.delete();
    end else begin
      // Register writes must come only while the block is idle; not enforced here
      if (cfg_we) begin
        case (cfg_index)
          REG_ENABLE: show_enable = cfg_data[0];
          REG_HOT_X:  hot_dx = cfg_data;
          REG_HOT_Y:  hot_dy = cfg_data;
          default:    ;
        endcase
      end

      // Compare a result transfer against the oldest prediction
      if (pop && !empty) begin
        seen = {pixel_out, cursor_shown};
        if (awaited_results.size() == 0) begin
          flag("result with nothing outstanding", '0, seen);
        end else begin
          want = awaited_results.pop_front();
          if (seen.pixel !== want.pixel || seen.shown !== want.shown) begin
            flag("result mismatch", want, seen);
          end
        end
      end

      // Predict the result of an item transfer and advance the mirror
      if (push && !full) begin
        want.pixel = '0;
        case (op)
          OPC_PIXEL: want.pixel = blended_pixel(pixel_in, pos_x, pos_y);
          OPC_LOAD: begin
            if (int'(row_index) < CURSOR_ROWS) begin
              clear_rows[row_index] = clear_bits;
              set_rows[row_index] = set_bits;
            end
          end
          OPC_MOVE: begin
            ptr_x = pos_x;
            ptr_y = pos_y;
          end
          OPC_HIDE:   if (hide_level != HIDE_MAX) hide_level = hide_level + 1'b1;
          OPC_UNHIDE: if (hide_level != '0) hide_level = hide_level - 1'b1;
          default:    ;
        endcase
        want.shown = cursor_visible();
        awaited_results.push_back(want);
      end
    end
    fail_count <= errors;
    pending <= awaited_results.size();
  end

endmodule

// ----- tb/testbench.sv -----
// Top of the cursor overlay testbench: clock, reset, item and register stimulus, result
// sink with random stalls, and the verdict. Depends on caxo_pkg, overlay_checker and the
// cursor_and_xor_overlay_unit RTL.
`timescale 1ns / 100ps

module testbench;
  import caxo_pkg::*;

  localparam int ITEMS_PER_SEG  = 125;
  localparam int SEG_COUNT      = 6;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int RX_HOLD_CYCLES = 64;
  localparam int HOLD_FIRST     = 200;
  localparam int HOLD_SECOND    = 560;
  localparam int HIDE_RUN       = 17;
  localparam int TAIL_CYCLES    = 8;

  typedef struct {
    logic [OP_W-1:0]       code;
    logic [POS_W-1:0]      x;
    logic [POS_W-1:0]      y;
    logic [PIXEL_BITS-1:0] pix;
    logic [ROW_W-1:0]      row;
    logic [PLANE_W-1:0]    clear_row;
    logic [PLANE_W-1:0]    set_row;
  } overlay_item_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  push = 1'b0;
  logic                  full;
  logic [OP_W-1:0]       op = '0;
  logic [POS_W-1:0]      pos_x = '0;
  logic [POS_W-1:0]      pos_y = '0;
  logic [PIXEL_BITS-1:0] pixel_in = '0;
  logic [ROW_W-1:0]      row_index = '0;
  logic [PLANE_W-1:0]    clear_bits = '0;
  logic [PLANE_W-1:0]    set_bits = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  logic [PIXEL_BITS-1:0] pixel_out;
  logic                  cursor_shown;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    fail_count;
  int                    pending;
  int                    cycle_count = 0;

  // Stimulus shaping: idle rates and what was last sent
  int               tx_idle_pct = 33;
  int               rx_idle_pct = 52;
  logic [POS_W-1:0] sent_ptr_x = '0;
  logic [POS_W-1:0] sent_ptr_y = '0;
  int               sent_hot_x = 0;
  int               sent_hot_y = 0;

  cursor_and_xor_overlay_unit dut (.*);
  overlay_checker checker_i (.*);

  always #5 clk = ~clk;

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic overlay_item_t make_item(input logic [OP_W-1:0] code,
                                              input logic [POS_W-1:0] x,
                                              input logic [POS_W-1:0] y,
                                              input logic [PIXEL_BITS-1:0] pix,
                                              input logic [ROW_W-1:0] row,
                                              input logic [PLANE_W-1:0] clear_row,
                                              input logic [PLANE_W-1:0] set_row);
    overlay_item_t it;
    it.code = code;
    it.x = x;
    it.y = y;
    it.pix = pix;
    it.row = row;
    it.clear_row = clear_row;
    it.set_row = set_row;
    return it;
  endfunction

  // Random content in every field, op given
  function automatic overlay_item_t noisy_item(input logic [OP_W-1:0] code);
    return make_item(code, POS_W'($urandom_range(0, 4095)), POS_W'($urandom_range(0, 4095)),
                     PIXEL_BITS'($urandom_range(0, 255)), ROW_W'($urandom_range(0, 15)),
                     PLANE_W'($urandom_range(0, 65535)), PLANE_W'($urandom_range(0, 65535)));
  endfunction

  // Pixel aimed at or just around the cursor rectangle, occasionally anywhere
  function automatic overlay_item_t pixel_item();
    overlay_item_t it;
    it = noisy_item(OPC_PIXEL);
    if ($urandom_range(0, 99) < 75) begin
      it.x = POS_W'(int'(sent_ptr_x) - sent_hot_x + int'($urandom_range(0, 19)) - 2);
      it.y = POS_W'(int'(sent_ptr_y) - sent_hot_y + int'($urandom_range(0, 19)) - 2);
    end
    return it;
  endfunction

  function automatic overlay_item_t random_item();
    overlay_item_t it;
    int            pick;
    pick = $urandom_range(0, 99);
    if (pick < 58) begin
      it = pixel_item();
    end else if (pick < 70) begin
      it = noisy_item(OPC_LOAD);
      case ($urandom_range(0, 3))
        0:       it.clear_row = '0;
        1:       it.set_row = '1;
        default: ;
      endcase
    end else if (pick < 78) begin
      it = noisy_item(OPC_MOVE);
      case ($urandom_range(0, 3))
        0: begin
          it.x = POS_W'($urandom_range(0, 20));
          it.y = POS_W'($urandom_range(0, 20));
        end
        1: begin
          it.x = POS_W'($urandom_range(4075, 4095));
          it.y = POS_W'($urandom_range(4075, 4095));
        end
        default: ;
      endcase
    end else if (pick < 86) begin
      it = noisy_item(OPC_HIDE);
    end else if (pick < 96) begin
      it = noisy_item(OPC_UNHIDE);
    end else begin
      it = noisy_item(OP_W'($urandom_range(int'(OPC_UNHIDE) + 1, 7)));
    end
    return it;
  endfunction

  // Offer one item and hold it until the transfer
  task automatic send_item(input overlay_item_t it);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    op <= it.code;
    pos_x <= it.x;
    pos_y <= it.y;
    pixel_in <= it.pix;
    row_index <= it.row;
    clear_bits <= it.clear_row;
    set_bits <= it.set_row;
    do @(posedge clk); while (full);
    if (it.code == OPC_MOVE) begin
      sent_ptr_x = it.x;
      sent_ptr_y = it.y;
    end
  endtask

  // Stop offering and wait until every predicted result has been popped
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Write all three registers back to back; the block must be idle
  task automatic apply_cfg(input logic en, input int hx, input int hy);
    cfg_we <= 1'b1;
    cfg_index <= REG_ENABLE;
    cfg_data <= {CFG_DATA_W'($urandom_range(0, 15)) << 1} | CFG_DATA_W'(en);
    @(posedge clk);
    cfg_index <= REG_HOT_X;
    cfg_data <= CFG_DATA_W'(hx);
    @(posedge clk);
    cfg_index <= REG_HOT_Y;
    cfg_data <= CFG_DATA_W'(hy);
    @(posedge clk);
    cfg_we <= 1'b0;
    sent_hot_x = hx;
    sent_hot_y = hy;
  endtask

  // Saturate the hide level, probe, then unwind past zero and probe again
  task automatic hide_storm();
    repeat (HIDE_RUN) send_item(noisy_item(OPC_HIDE));
    send_item(pixel_item());
    repeat (HIDE_RUN) send_item(noisy_item(OPC_UNHIDE));
    send_item(pixel_item());
  endtask

  // Result sink: random stalls, plus two long hold-offs to back the block up
  initial begin : result_sink
    int taken;
    int hold_at;
    taken = 0;
    hold_at = HOLD_FIRST;
    forever begin
      @(posedge clk);
      if (pop && !empty) taken++;
      if (!rst && taken >= hold_at) begin
        pop <= 1'b0;
        hold_at = (hold_at == HOLD_FIRST) ? HOLD_SECOND : (1 << 30);
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end
      pop <= !rst && ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Item and register stimulus
  initial begin : item_source
    logic en;
    int   hx;
    int   hy;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Cursor disabled after reset: pixels pass straight through
    send_item(make_item(OPC_PIXEL, 12'd5, 12'd5, 8'hA5, 4'd0, 16'h0000, 16'h0000));
    // Row 0 holds transparent, black, white and inverted columns in turn
    send_item(make_item(OPC_LOAD, 12'd0, 12'd0, 8'h00, 4'd0, 16'h3333, 16'h5555));
    send_item(make_item(OPC_LOAD, 12'hFFF, 12'hFFF, 8'hFF, 4'd15, 16'hFFFF, 16'hFFFF));
    send_item(make_item(OPC_LOAD, 12'd0, 12'd0, 8'h00, 4'd7, 16'h0000, 16'hFFFF));
    drain();
    apply_cfg(1'b1, 0, 0);

    // Each bit pair, the far corner and just outside the rectangle
    for (int c = 0; c < 4; c++) begin
      send_item(make_item(OPC_PIXEL, POS_W'(c), 12'd0, 8'h5A, 4'd0, 16'h0, 16'h0));
    end
    send_item(make_item(OPC_PIXEL, 12'd15, 12'd15, 8'h0F, 4'd0, 16'h0, 16'h0));
    send_item(make_item(OPC_PIXEL, 12'd16, 12'd15, 8'h0F, 4'd0, 16'h0, 16'h0));
    send_item(make_item(OPC_PIXEL, 12'd15, 12'd16, 8'h0F, 4'd0, 16'h0, 16'h0));
    send_item(make_item(OPC_PIXEL, 12'd4, 12'd7, 8'h00, 4'd0, 16'h0, 16'h0));
    // Pointer at the top of the coordinate range
    send_item(make_item(OPC_MOVE, 12'hFFF, 12'hFFF, 8'h00, 4'd0, 16'h0, 16'h0));
    send_item(make_item(OPC_PIXEL, 12'hFFF, 12'hFFF, 8'hFF, 4'd0, 16'h0, 16'h0));
    send_item(make_item(OPC_MOVE, 12'd0, 12'd0, 8'h00, 4'd0, 16'h0, 16'h0));
    // Hide masks the cursor; a second unhide stays at zero
    send_item(make_item(OPC_HIDE, 12'd0, 12'd0, 8'h00, 4'd0, 16'h0, 16'h0));
    send_item(make_item(OPC_PIXEL, 12'd2, 12'd0, 8'h3C, 4'd0, 16'h0, 16'h0));
    send_item(make_item(OPC_UNHIDE, 12'd0, 12'd0, 8'h00, 4'd0, 16'h0, 16'h0));
    send_item(make_item(OPC_UNHIDE, 12'd0, 12'd0, 8'h00, 4'd0, 16'h0, 16'h0));
    send_item(make_item(OPC_PIXEL, 12'd2, 12'd0, 8'h3C, 4'd0, 16'h0, 16'h0));
    // Unknown ops change nothing and give a zero pixel
    send_item(make_item(OP_W'(int'(OPC_UNHIDE) + 1), 12'hFFF, 12'hFFF, 8'hFF, 4'd15,
                        16'hFFFF, 16'hFFFF));
    send_item(make_item('1, 12'd1, 12'd1, 8'h81, 4'd1, 16'h8001, 16'h8001));

    // Random segments: idle pattern changes every two, registers every one
    for (int seg = 0; seg < SEG_COUNT; seg++) begin
      drain();
      en = 1'b1;
      hx = int'($urandom_range(0, 31)) - 16;
      hy = int'($urandom_range(0, 31)) - 16;
      case (seg)
        0: begin
          hx = -16;
          hy = 15;
        end
        1: begin
          hx = 15;
          hy = -16;
        end
        2: en = 1'b0;
        3: begin
          hx = 0;
          hy = 0;
        end
        default: ;
      endcase
      apply_cfg(en, hx, hy);
      case (seg / 2)
        0: begin
          tx_idle_pct = 33;
          rx_idle_pct = 52;
        end
        1: begin
          tx_idle_pct = 52;
          rx_idle_pct = 33;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      if (seg == 0 || seg == 3) hide_storm();
      repeat (ITEMS_PER_SEG) send_item(random_item());
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
